>>> rtl/ffha_pkg.sv
// Shared constants, types and codes for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int ArenaUnits  = 16384;
  localparam int UnitBytes   = 16;
  localparam int HeaderUnits = 2;
  localparam int PosW   = $clog2(ArenaUnits);
  localparam int LenW   = PosW + 1;
  localparam int ShiftW = $clog2(UnitBytes);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_STATS = 2'd2;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_NOFIT    = 3'd2;
  localparam logic [2:0] ST_BADADDR  = 3'd3;
  localparam logic [2:0] ST_NOTALLOC = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [19:0] request_bytes;
    logic [17:0] payload_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [17:0] granted_address;
    logic [17:0] free_payload_bytes;
    logic [17:0] largest_free_bytes;
    logic [12:0] allocated_count;
  } rsp_t;

  typedef struct packed {
    logic            used;
    logic [LenW-1:0] len;
  } hdr_t;
endpackage

>>> rtl/ffha_if.sv
// Valid/ready channel carrying one payload.
`timescale 1ns / 1ps
interface ffha_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ffha_hdr_ram.sv
// Header memory, one write port and one registered read port.
`timescale 1ns / 1ps
module ffha_hdr_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ffha_pkg::PosW-1:0]    waddr,
  input  ffha_pkg::hdr_t               wdata,
  input  logic [ffha_pkg::PosW-1:0]    raddr,
  output ffha_pkg::hdr_t               rdata
);
  ffha_pkg::hdr_t mem [ffha_pkg::ArenaUnits];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/first_fit_heap_allocator.sv
// First-fit heap allocator: top level with header walker and response register.
//
// One request at a time. Allocate, free and stats requests walk the block
// headers from unit 0 in a header memory with one read and one write port;
// zero-size allocates, misaligned or out-of-range free addresses and reserved
// operations answer without a walk. Free stops at the target block. After
// reset the init state writes the initial free header. A result waits in an
// output register; the next request is taken once it has been handed over.
`timescale 1ns / 1ps
module first_fit_heap_allocator (
  input logic clk,
  input logic rst,
  ffha_if.sink   req,
  ffha_if.source rsp
);
  localparam int PW = ffha_pkg::PosW;
  localparam int LW = ffha_pkg::LenW;
  localparam int SW = ffha_pkg::ShiftW;
  localparam int RW = $bits(ffha_pkg::rsp_t);
  localparam logic [LW-1:0] HDR = LW'(ffha_pkg::HeaderUnits);
  localparam logic [LW:0]   ARENA = (LW+1)'(ffha_pkg::ArenaUnits);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_NRD   = 4'd4;
  localparam logic [3:0] S_NEVAL = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PEVAL = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;
  ffha_pkg::req_t cur;
  ffha_pkg::rsp_t res;
  logic [LW:0] pos;
  logic [PW-1:0] prev;
  logic [PW-1:0] tgt_pos;
  logic has_prev;
  logic [LW-1:0] need;
  logic [LW-1:0] cur_len;
  logic [LW-1:0] target;
  logic [31:0] total;
  logic [31:0] largest;
  logic [12:0] count;

  // split header is written on the S_RD cycle after the allocate hit
  logic split_pend;
  logic [PW-1:0] split_at;
  logic [LW-1:0] split_len;
  logic split_we;

  logic we;
  logic [PW-1:0] waddr, raddr;
  ffha_pkg::hdr_t wdata, rdata;

  ffha_hdr_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  logic [LW:0] nxt;
  logic [LW:0] tgt_ext;
  logic [LW:0] rem;
  assign nxt = pos + (LW+1)'(HDR) + (LW+1)'(rdata.len);
  assign tgt_ext = (LW+1)'(target);
  assign rem = (LW+1)'(rdata.len) - (LW+1)'(need);

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data  = res;
  assign split_we = (state == S_RD) && split_pend;

  logic [20:0] need_w;
  assign need_w = (21'(req.data.request_bytes) + 21'(ffha_pkg::UnitBytes - 1)) >> SW;

  logic [2:0] idle_status;
  logic       idle_walk;
  always_comb begin
    idle_status = ffha_pkg::ST_DONE;
    idle_walk = 1'b0;
    priority if (req.data.operation == ffha_pkg::OP_ALLOC
                 && req.data.request_bytes == '0) begin
      idle_status = ffha_pkg::ST_ZERO;
    end else if (req.data.operation == ffha_pkg::OP_FREE
        && (req.data.payload_address[SW-1:0] != '0
            || 19'(req.data.payload_address)
               < 19'(ffha_pkg::HeaderUnits * ffha_pkg::UnitBytes)
            || 19'(req.data.payload_address)
               >= 19'(ffha_pkg::ArenaUnits * ffha_pkg::UnitBytes)))
    begin
      idle_status = ffha_pkg::ST_BADADDR;
    end else if (req.data.operation == ffha_pkg::OP_ALLOC
                 || req.data.operation == ffha_pkg::OP_FREE
                 || req.data.operation == ffha_pkg::OP_STATS) begin
      idle_walk = 1'b1;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = pos[PW-1:0];
    wdata = rdata;
    raddr = pos[PW-1:0];
    unique case (state)
      S_INIT: begin
        we = 1'b1;
        waddr = '0;
        wdata.used = 1'b0;
        wdata.len = LW'(ffha_pkg::ArenaUnits - ffha_pkg::HeaderUnits);
      end
      S_RD: begin
        if (split_we) begin
          we = 1'b1;
          waddr = split_at;
          wdata.used = 1'b0;
          wdata.len = split_len;
        end
      end
      S_EVAL: begin
        if (cur.operation == ffha_pkg::OP_ALLOC && !rdata.used
            && rdata.len >= need) begin
          we = 1'b1;
          wdata.used = 1'b1;
          if (rem >= (LW+1)'(HDR) + 1'b1) wdata.len = need;
        end else if (cur.operation == ffha_pkg::OP_FREE
                     && pos + (LW+1)'(HDR) == tgt_ext && rdata.used) begin
          we = 1'b1;
          wdata.used = 1'b0;
        end
      end
      S_NRD: raddr = nxt[PW-1:0];
      S_NEVAL: begin
        if (pos < ARENA && !rdata.used) begin
          we = 1'b1;
          waddr = tgt_pos;
          wdata.used = 1'b0;
          wdata.len = cur_len + HDR + rdata.len;
        end
      end
      S_PRD: raddr = prev;
      S_PEVAL: begin
        waddr = prev;
        wdata.len = rdata.len + HDR + cur_len;
        we = !rdata.used;
      end
      S_IDLE, S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      split_pend <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (req.valid) begin
            cur <= req.data;
            res <= {idle_status, (RW-3)'(0)};
            pos <= '0;
            has_prev <= 1'b0;
            total <= '0;
            largest <= '0;
            count <= '0;
            need <= (need_w > 21'(ARENA)) ? {LW{1'b1}} : LW'(need_w);
            target <= LW'(req.data.payload_address >> SW);
            state <= idle_walk ? S_RD : S_OUT;
          end
        end
        S_RD: begin
          if (split_pend) begin
            split_pend <= 1'b0;
            state <= S_OUT;
          end else if (pos >= ARENA) begin
            if (cur.operation == ffha_pkg::OP_ALLOC)
              res.status <= ffha_pkg::ST_NOFIT;
            else if (cur.operation == ffha_pkg::OP_FREE)
              res.status <= ffha_pkg::ST_BADADDR;
            else
              res <= {ffha_pkg::ST_DONE, 18'd0, total[17:0], largest[17:0], count};
            state <= S_OUT;
          end else state <= S_EVAL;
        end
        S_EVAL: begin
          cur_len <= rdata.len;
          if (cur.operation == ffha_pkg::OP_ALLOC) begin
            if (!rdata.used && rdata.len >= need) begin
              res.granted_address <= {pos[PW-1:0] + PW'(HDR), {SW{1'b0}}};
              if (rem >= (LW+1)'(HDR) + 1'b1) begin
                split_pend <= 1'b1;
                split_at <= PW'(pos + (LW+1)'(HDR) + (LW+1)'(need));
                split_len <= LW'(rem - (LW+1)'(HDR));
                state <= S_RD;
              end else state <= S_OUT;
            end else begin
              pos <= nxt;
              state <= S_RD;
            end
          end else if (cur.operation == ffha_pkg::OP_FREE) begin
            if (pos + (LW+1)'(HDR) == tgt_ext) begin
              if (!rdata.used) begin
                res.status <= ffha_pkg::ST_NOTALLOC;
                state <= S_OUT;
              end else state <= S_NRD;
            end else if (pos + (LW+1)'(HDR) > tgt_ext) begin
              res.status <= ffha_pkg::ST_BADADDR;
              state <= S_OUT;
            end else begin
              prev <= pos[PW-1:0];
              has_prev <= 1'b1;
              pos <= nxt;
              state <= S_RD;
            end
          end else begin
            if (rdata.used) count <= count + 1'b1;
            else begin
              total <= total + (32'(rdata.len) << SW);
              if ((32'(rdata.len) << SW) > largest) largest <= 32'(rdata.len) << SW;
            end
            pos <= nxt;
            state <= S_RD;
          end
        end
        S_NRD: begin
          // rdata still holds the target header; step to the next neighbor
          tgt_pos <= pos[PW-1:0];
          pos <= nxt;
          state <= S_NEVAL;
        end
        S_NEVAL: begin
          if (pos < ARENA && !rdata.used) cur_len <= cur_len + HDR + rdata.len;
          state <= has_prev ? S_PRD : S_OUT;
        end
        S_PRD: state <= S_PEVAL;
        S_PEVAL: state <= S_OUT;
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_INIT;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_split_only_alloc: assert property (@(posedge clk) disable iff (rst)
    split_pend |-> cur.operation == ffha_pkg::OP_ALLOC)
    else $error("split pending outside allocate");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !rsp.ready) |=> state == S_OUT && $stable(res))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready)
    else $error("request taken while busy");
`endif
endmodule

>>> sim/ffha_tb_if.sv
// Testbench-side constants for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_tb_pkg;
  localparam int ArenaBytes = ffha_pkg::ArenaUnits * ffha_pkg::UnitBytes;
  localparam logic [1:0] OP_RSVD = 2'd3;
endpackage

>>> sim/testbench.sv
// Testbench for the first-fit heap allocator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ffha_if #(.T(ffha_pkg::req_t)) req (clk);
  ffha_if #(.T(ffha_pkg::rsp_t)) rsp (clk);

  first_fit_heap_allocator dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // predictor state: payload length and used flag at each block start
  int unsigned heap_len[ffha_pkg::ArenaUnits];
  bit heap_used[ffha_pkg::ArenaUnits];
  ffha_pkg::rsp_t expected_rsp[$];
  int unsigned granted[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_kick = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int burst_left = 0;

  function automatic ffha_pkg::rsp_t predict(ffha_pkg::req_t r);
    ffha_pkg::rsp_t o;
    int unsigned pos, prev, need, rem, tgt, nxt;
    bit has_prev;
    longint unsigned tot, big, b;
    int unsigned cnt;
    o = '0;
    pos = 0;
    if (r.operation == ffha_pkg::OP_ALLOC) begin
      if (r.request_bytes == 0) begin
        o.status = ffha_pkg::ST_ZERO;
        return o;
      end
      need = (r.request_bytes + ffha_pkg::UnitBytes - 1) / ffha_pkg::UnitBytes;
      while (pos < ffha_pkg::ArenaUnits) begin
        if (!heap_used[pos] && heap_len[pos] >= need) begin
          rem = heap_len[pos] - need;
          if (rem >= ffha_pkg::HeaderUnits + 1) begin
            heap_len[pos + ffha_pkg::HeaderUnits + need] = rem - ffha_pkg::HeaderUnits;
            heap_used[pos + ffha_pkg::HeaderUnits + need] = 0;
            heap_len[pos] = need;
          end
          heap_used[pos] = 1;
          o.status = ffha_pkg::ST_DONE;
          o.granted_address = 18'((pos + ffha_pkg::HeaderUnits) * ffha_pkg::UnitBytes);
          return o;
        end
        pos = pos + ffha_pkg::HeaderUnits + heap_len[pos];
      end
      o.status = ffha_pkg::ST_NOFIT;
    end else if (r.operation == ffha_pkg::OP_FREE) begin
      if (r.payload_address % ffha_pkg::UnitBytes != 0
          || r.payload_address < ffha_pkg::HeaderUnits * ffha_pkg::UnitBytes
          || r.payload_address >= ffha_tb_pkg::ArenaBytes) begin
        o.status = ffha_pkg::ST_BADADDR;
        return o;
      end
      tgt = r.payload_address / ffha_pkg::UnitBytes;
      prev = 0;
      has_prev = 0;
      while (pos < ffha_pkg::ArenaUnits) begin
        if (pos + ffha_pkg::HeaderUnits == tgt) begin
          if (!heap_used[pos]) begin
            o.status = ffha_pkg::ST_NOTALLOC;
            return o;
          end
          heap_used[pos] = 0;
          nxt = pos + ffha_pkg::HeaderUnits + heap_len[pos];
          if (nxt < ffha_pkg::ArenaUnits && !heap_used[nxt])
            heap_len[pos] += ffha_pkg::HeaderUnits + heap_len[nxt];
          if (has_prev && !heap_used[prev])
            heap_len[prev] += ffha_pkg::HeaderUnits + heap_len[pos];
          o.status = ffha_pkg::ST_DONE;
          return o;
        end
        if (pos + ffha_pkg::HeaderUnits > tgt) break;
        prev = pos;
        has_prev = 1;
        pos = pos + ffha_pkg::HeaderUnits + heap_len[pos];
      end
      o.status = ffha_pkg::ST_BADADDR;
    end else if (r.operation == ffha_pkg::OP_STATS) begin
      tot = 0;
      big = 0;
      cnt = 0;
      while (pos < ffha_pkg::ArenaUnits) begin
        if (heap_used[pos]) cnt++;
        else begin
          b = heap_len[pos] * ffha_pkg::UnitBytes;
          tot += b;
          if (b > big) big = b;
        end
        pos = pos + ffha_pkg::HeaderUnits + heap_len[pos];
      end
      o.status = ffha_pkg::ST_DONE;
      o.free_payload_bytes = 18'(tot);
      o.largest_free_bytes = 18'(big);
      o.allocated_count = 13'(cnt);
    end
    return o;
  endfunction

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    heap_len[0] = ffha_pkg::ArenaUnits - ffha_pkg::HeaderUnits;
  end

  task automatic send_request(input logic [1:0] op, input int unsigned bytes,
                              input int unsigned addr);
    ffha_pkg::req_t r;
    ffha_pkg::rsp_t e;
    int gap;
    r.operation = op;
    r.request_bytes = 20'(bytes);
    r.payload_address = 18'(addr);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 20)) : 0;
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk); while (!req.ready);
    e = predict(r);
    if (op == ffha_pkg::OP_ALLOC && e.status == ffha_pkg::ST_DONE)
      granted.push_back(e.granted_address);
    expected_rsp.push_back(e);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (expected_rsp.size() != 0);
  endtask

  task automatic free_random_grant();
    int k;
    if (granted.size() == 0) return;
    k = $urandom_range(0, granted.size() - 1);
    send_request(ffha_pkg::OP_FREE, 0, granted[k]);
    granted.delete(k);
  endtask

  task automatic test_directed();
    send_request(ffha_pkg::OP_STATS, 0, 0);
    send_request(ffha_pkg::OP_ALLOC, 0, 0);
    send_request(ffha_pkg::OP_ALLOC, 20'hFFFFF, 0);
    send_request(ffha_pkg::OP_ALLOC, 1, 0);
    send_request(ffha_pkg::OP_ALLOC, 16, 0);
    send_request(ffha_pkg::OP_ALLOC, 17, 0);
    send_request(ffha_pkg::OP_FREE, 0, 0);
    send_request(ffha_pkg::OP_FREE, 0, 18'h3FFFF);
    send_request(ffha_pkg::OP_FREE, 0, 33);
    send_request(ffha_pkg::OP_FREE, 0, 48);
    send_request(ffha_pkg::OP_FREE, 0, 32);
    send_request(ffha_pkg::OP_FREE, 0, 32);
    send_request(ffha_pkg::OP_FREE, 0, 80);
    send_request(ffha_tb_pkg::OP_RSVD, 20'hFFFFF, 18'h3FFFF);
    send_request(ffha_pkg::OP_STATS, 0, 0);
    send_request(ffha_pkg::OP_ALLOC,
                 (ffha_pkg::ArenaUnits - ffha_pkg::HeaderUnits) * ffha_pkg::UnitBytes, 0);
    send_request(ffha_pkg::OP_STATS, 0, 0);
    send_request(ffha_pkg::OP_ALLOC, 1, 0);
    send_request(ffha_pkg::OP_FREE, 0, 80);
    send_request(ffha_pkg::OP_FREE, 0, 32);
    send_request(ffha_pkg::OP_STATS, 0, 0);
    granted.delete();
    drain();
  endtask

  task automatic test_random(input int n);
    int c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 99);
      if (c < 45) begin
        send_request(ffha_pkg::OP_ALLOC, $urandom_range(0, 9) == 0 ? $urandom() & 20'hFFFFF
                     : $urandom_range(1, 600), $urandom());
      end else if (c < 80 && granted.size() != 0) free_random_grant();
      else if (c < 88) send_request(ffha_pkg::OP_FREE, $urandom(), $urandom() & 18'h3FFFF);
      else if (c < 97) send_request(ffha_pkg::OP_STATS, $urandom(), $urandom());
      else send_request(ffha_tb_pkg::OP_RSVD, $urandom(), $urandom());
    end
  endtask

  task automatic test_backpressure();
    hold_kick++;
    for (int i = 0; i < 6; i++) begin
      if (i % 2 == 0) send_request(ffha_pkg::OP_ALLOC, 0, 0);
      else send_request(ffha_tb_pkg::OP_RSVD, 0, 0);
    end
    drain();
    test_random(20);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500);
    test_backpressure();
    test_random(500);
    while (granted.size() != 0) free_random_grant();
    send_request(ffha_pkg::OP_STATS, 0, 0);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // receiver stall pattern, plus a long hold of its own length
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_kick) begin
      hold_seen <= hold_kick;
      hold_left <= 300;
      rsp.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else rsp.ready <= ($urandom_range(0, 7) < 5) || ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    ffha_pkg::rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", rsp.data);
      end else begin
        e = expected_rsp.pop_front();
        if (rsp.data !== e) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", e, rsp.data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule

>>> filelist.f
rtl/ffha_pkg.sv
rtl/ffha_if.sv
rtl/ffha_hdr_ram.sv
rtl/first_fit_heap_allocator.sv
sim/ffha_tb_if.sv
sim/testbench.sv
